[rtl/gwe_pkg.sv]
// Shared types, constants and codes of the graph walk engine.
package gwe_pkg;
   localparam int NodeCountDefault = 16;
   localparam int MaxDegreeDefault = 8;
   localparam int KIND_W = 2;
   localparam int NODE_W = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_CHECK = 2'd1,
      KIND_BFS   = 2'd2,
      KIND_DFS   = 2'd3
   } kind_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request fields
      logic clr_visit;   // clear visited marks
      logic push_start;  // write start into buffer, reset pointers
      logic start_node;  // cur := popped/head node read
      logic nb_read;     // issue neighbor read for cur, index d
      logic nb_eval;     // evaluate returned neighbor
      logic buf_read;    // issue buffer read
      logic add_do;      // perform add write
      logic emit;        // mark cur visited/known for emit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pair_ok;     // from and to nodes both in range
      logic src_known;
      logic full;
      logic nb_done;     // d reached degree (or zero)
      logic buf_empty;
      logic cur_visited;
      logic hit;
   } stat_type;
endpackage

[rtl/gwe_if.sv]
// Valid/ready channel interfaces for request and response items.
interface gwe_req_if;
   logic                         valid;
   logic                         ready;
   logic [gwe_pkg::KIND_W-1:0]   kind;
   logic [gwe_pkg::NODE_W-1:0]   from_node;
   logic [gwe_pkg::NODE_W-1:0]   to_node;
   modport source (output valid, kind, from_node, to_node, input ready);
   modport sink (input valid, kind, from_node, to_node, output ready);
endinterface

interface gwe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gwe_pkg::STATUS_W-1:0] status;
   logic [gwe_pkg::NODE_W-1:0]   node;
   logic                         found;
   logic                         last;
   modport source (output valid, status, node, found, last, input ready);
   modport sink (input valid, status, node, found, last, output ready);
endinterface

[rtl/gwe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gwe_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[rtl/gwe_datapath.sv]
// Datapath: graph store, degree and mark registers, walk buffer and pointers.
module gwe_datapath #(
   parameter int NODE_COUNT = gwe_pkg::NodeCountDefault,
   parameter int MAX_DEGREE = gwe_pkg::MaxDegreeDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gwe_pkg::cmd_type           cmd,
   input  logic [gwe_pkg::KIND_W-1:0] req_kind,
   input  logic [gwe_pkg::NODE_W-1:0] req_from_node,
   input  logic [gwe_pkg::NODE_W-1:0] req_to_node,
   output gwe_pkg::stat_type          stat,
   output logic [gwe_pkg::NODE_W-1:0] cur_node
);
   import gwe_pkg::*;
   localparam int SLOTS = NODE_COUNT * MAX_DEGREE;
   localparam int NI_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int DG_W = $clog2(MAX_DEGREE + 1);
   localparam int DI_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int SA_W = $clog2(SLOTS);
   localparam int BD = SLOTS + 1;
   localparam int BA_W = $clog2(BD);
   localparam int BC_W = $clog2(BD + 1);

   logic [NODE_W-1:0] src_ff, dst_ff, cur_ff;
   logic              bfs_ff;
   logic [DG_W-1:0]   degree_ff [NODE_COUNT];
   logic [NODE_COUNT-1:0] known_ff, visit_ff;
   logic [DG_W-1:0]   d_ff;          // neighbors issued
   logic [BC_W-1:0]   head_ff, tail_ff;  // bfs: head/tail; dfs: tail is top
   logic              cur_ok;

   logic [NI_W-1:0]   src_i, dst_i, cur_i;
   assign src_i = src_ff[NI_W-1:0];
   assign dst_i = dst_ff[NI_W-1:0];
   assign cur_i = cur_ff[NI_W-1:0];

   logic src_ok, dst_ok;
   assign src_ok = 32'(src_ff) < NODE_COUNT;
   assign dst_ok = 32'(dst_ff) < NODE_COUNT;
   assign cur_ok = 32'(cur_ff) < NODE_COUNT;

   // neighbor store
   logic              nb_wen;
   logic [SA_W-1:0]   nb_waddr, nb_raddr;
   logic [NODE_W-1:0] nb_rdata;
   logic [DG_W-1:0]   cur_deg;
   logic [DI_W-1:0]   rd_idx;

   assign cur_deg = degree_ff[cur_i];
   assign nb_wen  = cmd.add_do && src_ok && dst_ok && !stat.full;
   assign nb_waddr = SA_W'(32'(src_i) * MAX_DEGREE + 32'(degree_ff[src_i]));
   // bfs reads forward; dfs reads reverse
   assign rd_idx = bfs_ff ? DI_W'(d_ff) : DI_W'(cur_deg - d_ff - DG_W'(1));
   assign nb_raddr = SA_W'(32'(cur_i) * MAX_DEGREE + 32'(rd_idx));

   gwe_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_nb (
      .clock(clock), .wr_en(nb_wen), .wr_addr(nb_waddr), .wr_data(dst_ff),
      .rd_addr(nb_raddr), .rd_data(nb_rdata)
   );

   // walk buffer
   logic              bf_wen;
   logic [BA_W-1:0]   bf_waddr, bf_raddr;
   logic [NODE_W-1:0] bf_wdata, bf_rdata;
   logic              nb_ok, nb_take;
   logic [NI_W-1:0]   nb_i;

   assign nb_i  = nb_rdata[NI_W-1:0];
   assign nb_ok = 32'(nb_rdata) < NODE_COUNT;
   assign nb_take = cmd.nb_eval && nb_ok && !visit_ff[nb_i] &&
                    (bfs_ff ? (32'(tail_ff) < NODE_COUNT) : (32'(tail_ff) < BD));
   assign bf_wen   = cmd.push_start || nb_take;
   assign bf_waddr = cmd.push_start ? '0 : BA_W'(tail_ff);
   assign bf_wdata = cmd.push_start ? src_ff : nb_rdata;
   assign bf_raddr = bfs_ff ? BA_W'(head_ff) : BA_W'(tail_ff - BC_W'(1));

   gwe_ram #(.WIDTH(NODE_W), .DEPTH(BD)) u_buf (
      .clock(clock), .wr_en(bf_wen), .wr_addr(bf_waddr), .wr_data(bf_wdata),
      .rd_addr(bf_raddr), .rd_data(bf_rdata)
   );

   // check: scan compare
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         for (int i = 0; i < NODE_COUNT; i++) degree_ff[i] <= '0;
      end else begin
         if (cmd.add_do && src_ok && dst_ok) begin
            known_ff[src_i] <= 1'b1;
            if (!stat.full) degree_ff[src_i] <= degree_ff[src_i] + DG_W'(1);
         end
         if (cmd.emit && bfs_ff) known_ff[cur_i] <= 1'b1;
      end
      if (cmd.load) begin
         src_ff <= req_from_node;
         dst_ff <= req_to_node;
         bfs_ff <= (req_kind == KIND_BFS) || (req_kind == KIND_CHECK);
         hit_ff <= 1'b0;
      end
      // bfs marks the start as soon as it is queued
      if (cmd.clr_visit)
         visit_ff <= (bfs_ff && cmd.push_start) ? (NODE_COUNT'(1) << src_i) : '0;
      if (cmd.push_start) begin
         head_ff <= '0;
         tail_ff <= BC_W'(1);
         cur_ff  <= src_ff;
         d_ff    <= '0;
      end
      if (cmd.buf_read) begin
         if (bfs_ff) head_ff <= head_ff + BC_W'(1);
         else tail_ff <= tail_ff - BC_W'(1);
      end
      if (cmd.start_node) begin
         cur_ff <= bf_rdata;
         d_ff   <= '0;
      end
      if (cmd.emit) begin
         visit_ff[cur_i] <= 1'b1;
         d_ff <= '0;
      end
      if (cmd.nb_read) d_ff <= d_ff + DG_W'(1);
      if (nb_take) begin
         tail_ff <= tail_ff + BC_W'(1);
         if (bfs_ff) visit_ff[nb_i] <= 1'b1;
      end
      if (cmd.nb_eval && dst_ok && nb_rdata == dst_ff) hit_ff <= 1'b1;
   end

   assign stat.pair_ok     = src_ok && dst_ok;
   assign stat.src_known   = src_ok && known_ff[src_i];
   assign stat.full        = 32'(degree_ff[src_i]) >= MAX_DEGREE;
   assign stat.nb_done     = !cur_ok || d_ff >= cur_deg;
   assign stat.buf_empty   = bfs_ff ? (head_ff == tail_ff) : (tail_ff == '0);
   assign stat.cur_visited = cur_ok && visit_ff[cur_i];
   assign stat.hit         = hit_ff;
   assign cur_node = cur_ff;
endmodule

[rtl/gwe_ctrl.sv]
// Controller: sequences add, check and walks; drives the response register.
module gwe_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   gwe_req_if.sink                    req,
   gwe_rsp_if.source                  rsp,
   input  gwe_pkg::stat_type          stat,
   input  logic [gwe_pkg::NODE_W-1:0] cur_node,
   output gwe_pkg::cmd_type           cmd
);
   import gwe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CHK_RD, S_CHK_EV, S_CHK_END, S_WSTART,
      S_POP_RD, S_POP_WAIT, S_POP, S_EMIT, S_NB_RD, S_NB_EV, S_PEND, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic              rv_ff, rv_in;
   logic [STATUS_W-1:0] rs_ff, rs_in;
   logic [NODE_W-1:0] rn_ff, rn_in;
   logic              rf_ff, rf_in, rl_ff, rl_in;
   // a walk holds its emitted node until the next or the end is known
   logic              pend_ff, pend_in;
   logic [NODE_W-1:0] pn_ff, pn_in;
   logic              out_free;

   assign out_free = !rv_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff; kind_in = kind_ff;
      rv_in = rv_ff && !rsp.ready;
      rs_in = rs_ff; rn_in = rn_ff; rf_in = rf_ff; rl_in = rl_ff;
      pend_in = pend_ff; pn_in = pn_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (req.valid) begin
            cmd.load = 1'b1; kind_in = req.kind; state_in = S_DECODE;
         end
         S_DECODE: if (out_free) begin
            unique case (kind_type'(kind_ff))
               KIND_ADD: begin
                  cmd.add_do = 1'b1; rv_in = 1'b1; rn_in = '0; rf_in = 1'b0;
                  rl_in = 1'b1; state_in = S_IDLE;
                  rs_in = !stat.pair_ok ? STATUS_NOTFOUND :
                          stat.full ? STATUS_FULL : STATUS_OK;
               end
               default: if (!stat.src_known) begin
                  rv_in = 1'b1; rs_in = STATUS_NOTFOUND; rn_in = '0;
                  rf_in = 1'b0; rl_in = 1'b1; state_in = S_IDLE;
               end else begin
                  cmd.clr_visit = 1'b1; cmd.push_start = 1'b1;
                  pend_in = 1'b0;
                  state_in = (kind_ff == KIND_CHECK) ? S_CHK_RD : S_WSTART;
               end
            endcase
         end
         S_CHK_RD: if (stat.nb_done) state_in = S_CHK_END;
            else begin cmd.nb_read = 1'b1; state_in = S_CHK_EV; end
         S_CHK_EV: begin cmd.nb_eval = 1'b1; state_in = S_CHK_RD; end
         S_CHK_END: if (out_free) begin
            rv_in = 1'b1; rs_in = STATUS_OK; rn_in = '0; rf_in = stat.hit;
            rl_in = 1'b1; state_in = S_IDLE;
         end
         S_WSTART: state_in = S_POP_RD;
         S_POP_RD: if (stat.buf_empty) state_in = S_PEND;
            else begin cmd.buf_read = 1'b1; state_in = S_POP_WAIT; end
         S_POP_WAIT: begin cmd.start_node = 1'b1; state_in = S_POP; end
         S_POP: state_in = stat.cur_visited && kind_ff == KIND_DFS ? S_POP_RD : S_EMIT;
         S_EMIT: if (!pend_ff || out_free) begin
            if (pend_ff) begin
               rv_in = 1'b1; rs_in = STATUS_OK; rn_in = pn_ff; rf_in = 1'b0;
               rl_in = 1'b0;
            end
            pend_in = 1'b1; pn_in = cur_node; cmd.emit = 1'b1;
            state_in = S_NB_RD;
         end
         S_NB_RD: if (stat.nb_done) state_in = S_POP_RD;
            else begin cmd.nb_read = 1'b1; state_in = S_NB_EV; end
         S_NB_EV: begin cmd.nb_eval = 1'b1; state_in = S_NB_RD; end
         S_PEND: if (out_free) begin
            rv_in = 1'b1; rs_in = STATUS_OK; rn_in = pn_ff; rf_in = 1'b0;
            rl_in = 1'b1; pend_in = 1'b0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; pend_ff <= pend_in;
      end
      kind_ff <= kind_in; rs_ff <= rs_in; rn_ff <= rn_in;
      rf_ff <= rf_in; rl_ff <= rl_in; pn_ff <= pn_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.status = rs_ff;
   assign rsp.node = rn_ff;
   assign rsp.found = rf_ff;
   assign rsp.last = rl_ff;
endmodule

[rtl/graph_walk_engine.sv]
// Top level of the graph walk engine: controller plus datapath.
// Usage:
//   req carries one item (kind, from_node, to_node); rsp returns result items
//   (status, node, found, last). last marks the final item of each request.
//   Add and an unknown source are answered from the decode step, with no walk.
//   A check reads the stored neighbors of the source one by one and compares
//   each with to_node. A walk pops a node from the buffer, emits it and reads
//   its neighbors one at a time through the single read port of the neighbor
//   RAM; a depth-first walk skips stack entries that are already visited. One
//   request is handled at a time; req.ready is high only between requests.
//   Each walk node is held one step so last can be set on the final one; a
//   single output register holds an item while rsp.ready is low, and the
//   walk pauses until it is taken.
//   Reset clears degrees, known marks and handshake state; the neighbor
//   store needs no clearing since only written entries are read.
module graph_walk_engine #(
   parameter int NODE_COUNT = gwe_pkg::NodeCountDefault,
   parameter int MAX_DEGREE = gwe_pkg::MaxDegreeDefault
) (
   input logic       clock,
   input logic       reset,
   gwe_req_if.sink   req,
   gwe_rsp_if.source rsp
);
   import gwe_pkg::*;
   cmd_type  cmd;
   stat_type stat;
   logic [NODE_W-1:0] cur_node;

   gwe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .stat(stat), .cur_node(cur_node), .cmd(cmd)
   );

   gwe_datapath #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_kind(req.kind), .req_from_node(req.from_node),
      .req_to_node(req.to_node), .stat(stat), .cur_node(cur_node)
   );
endmodule
